// File: sv/twph_pkg.sv
// Shared types and constants of the trace window pulse height block.
`timescale 1ns / 1ps

package twph_pkg;

  localparam int MAX_TRACE_LEN = 4096;
  localparam int IDX_W         = 13;
  localparam int SAMPLE_W      = 16;
  localparam int SUM_W         = 29;
  localparam int DEN_W         = 13;
  localparam int VAL_W         = 33;
  localparam int FRAC_BITS     = 16;
  localparam int EDGE_SAMPLES  = 10;
  localparam int QUEUE_DEPTH   = 2;
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 13;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MODE       = 3'd0,
    REG_BASE_START = 3'd1,
    REG_BASE_END   = 3'd2,
    REG_WIN_START  = 3'd3,
    REG_WIN_END    = 3'd4
  } cfg_reg_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_SHORT     = 2'd2,
    ST_NO_WINDOW = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    JOB_STATUS = 2'd0,
    JOB_HEIGHT = 2'd1,
    JOB_WINDOW = 2'd2
  } job_e;

  typedef enum logic [1:0] {
    BK_IDLE  = 2'd0,
    BK_DIV_A = 2'd1,
    BK_DIV_B = 2'd2,
    BK_DONE  = 2'd3
  } back_state_e;

  typedef struct packed {
    logic                      mode;
    logic [IDX_W-1:0]          baseline_start;
    logic [IDX_W-1:0]          baseline_end;
    logic [IDX_W-1:0]          window_start;
    logic [IDX_W-1:0]          window_end;
  } cfg_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       last;
    logic                       empty_trace;
  } in_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] value;
    logic [1:0]              status;
  } out_t;

  // One finished trace, classified: either a final status or one or two divisions.
  typedef struct packed {
    job_e                    kind;
    status_e                 status;
    logic signed [SUM_W-1:0] num_a;
    logic [DEN_W-1:0]        den_a;
    logic signed [SUM_W-1:0] num_b;
    logic [DEN_W-1:0]        den_b;
  } job_t;

  typedef struct packed {
    logic valid;
    logic full;
  } queue_stat_t;

endpackage

// File: sv/twph_queue.sv
// Short job queue between the sample front end and the division back end.
`timescale 1ns / 1ps

module twph_queue
  import twph_pkg::*;
#(
  parameter int Depth = QUEUE_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  job_t        push_data_i,
  input  logic        pop_i,
  output job_t        head_o,
  output queue_stat_t stat_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  job_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_push, do_pop;

  assign stat_o.valid = (count_q != '0);
  assign stat_o.full  = (count_q == CntW'(Depth));
  assign do_push      = push_i & ~stat_o.full;
  assign do_pop       = pop_i & stat_o.valid;
  assign head_o       = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Depth))
    else $error("job queue count beyond depth");

  a_no_lost_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !stat_o.full)
    else $error("job pushed into a full queue");

endmodule

// File: sv/twph_front.sv
// Front end: counts samples, keeps baseline, window, head and tail sums, classifies each trace end.
`timescale 1ns / 1ps

module twph_front
  import twph_pkg::*;
#(
  parameter int EdgeSamples = EDGE_SAMPLES
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cfg_t        cfg_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  in_t         in_data_i,
  input  queue_stat_t q_stat_i,
  output logic        push_o,
  output job_t        job_o
);

  localparam int EdgeW  = SAMPLE_W + $clog2(EdgeSamples);
  localparam int MinLen = 2 * EdgeSamples;

  logic [IDX_W-1:0]          idx_q, len_n;
  logic signed [SUM_W-1:0]   base_q, base_n;
  logic signed [SUM_W-1:0]   integ_q, integ_n;
  logic signed [EdgeW-1:0]   head_q, head_n;
  logic signed [EdgeW-1:0]   tail_q, tail_n;
  logic signed [EdgeW:0]     tail_full;
  logic signed [EdgeW:0]     height_num;
  logic signed [SAMPLE_W-1:0] tap_q [EdgeSamples];
  logic                      count_en, in_base, in_win, in_head;
  logic                      accept, trace_end;

  assign trace_end  = in_data_i.last | in_data_i.empty_trace;
  // Hold only the final word of a trace while the queue is full.
  assign in_ready_o = ~q_stat_i.full | ~trace_end;
  assign accept     = in_valid_i & in_ready_o;
  assign push_o     = accept & trace_end;

  assign count_en = (idx_q < IDX_W'(MAX_TRACE_LEN));
  assign in_base  = (idx_q >= cfg_i.baseline_start) && (idx_q < cfg_i.baseline_end);
  assign in_win   = (idx_q >= cfg_i.window_start) && (idx_q < cfg_i.window_end);
  assign in_head  = (idx_q < IDX_W'(EdgeSamples));

  always_comb begin
    len_n   = idx_q;
    base_n  = base_q;
    integ_n = integ_q;
    head_n  = head_q;
    tail_n  = tail_q;
    // Tail sum gains the new sample and drops the one that falls off the shift line.
    tail_full = EdgeW'(tail_q) + (EdgeW + 1)'(in_data_i.sample)
              - (EdgeW + 1)'(tap_q[EdgeSamples-1]);
    if (count_en) begin
      len_n  = idx_q + 1'b1;
      tail_n = EdgeW'(tail_full);
      if (in_base) begin
        base_n = base_q + SUM_W'(in_data_i.sample);
      end
      if (in_win) begin
        integ_n = integ_q + SUM_W'(in_data_i.sample);
      end
      if (in_head) begin
        head_n = head_q + EdgeW'(in_data_i.sample);
      end
    end
  end

  assign height_num = (EdgeW + 1)'(tail_n) - (EdgeW + 1)'(head_n);

  always_comb begin
    job_o.kind   = JOB_STATUS;
    job_o.status = ST_OK;
    job_o.num_a  = integ_n;
    job_o.den_a  = cfg_i.window_end - cfg_i.window_start;
    job_o.num_b  = base_n;
    job_o.den_b  = cfg_i.baseline_end - cfg_i.baseline_start;
    priority if (in_data_i.empty_trace) begin
      job_o.status = ST_EMPTY;
    end else if (cfg_i.mode) begin
      if (len_n < IDX_W'(MinLen)) begin
        job_o.status = ST_SHORT;
      end else begin
        job_o.kind  = JOB_HEIGHT;
        job_o.num_a = SUM_W'(height_num);
        job_o.den_a = DEN_W'(EdgeSamples);
      end
    end else if (len_n < cfg_i.window_end || len_n < cfg_i.baseline_end) begin
      job_o.status = ST_SHORT;
    end else if (cfg_i.window_end <= cfg_i.window_start ||
                 cfg_i.baseline_end <= cfg_i.baseline_start) begin
      job_o.status = ST_NO_WINDOW;
    end else begin
      job_o.kind = JOB_WINDOW;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      base_q  <= '0;
      integ_q <= '0;
      head_q  <= '0;
      tail_q  <= '0;
      for (int k = 0; k < EdgeSamples; k++) begin
        tap_q[k] <= '0;
      end
    end else if (accept) begin
      if (trace_end) begin
        idx_q   <= '0;
        base_q  <= '0;
        integ_q <= '0;
        head_q  <= '0;
        tail_q  <= '0;
        for (int k = 0; k < EdgeSamples; k++) begin
          tap_q[k] <= '0;
        end
      end else if (count_en) begin
        idx_q   <= len_n;
        base_q  <= base_n;
        integ_q <= integ_n;
        head_q  <= head_n;
        tail_q  <= tail_n;
        tap_q[0] <= in_data_i.sample;
        for (int k = 1; k < EdgeSamples; k++) begin
          tap_q[k] <= tap_q[k-1];
        end
      end
    end
  end

  a_idx_saturates: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q <= IDX_W'(MAX_TRACE_LEN))
    else $error("sample count beyond trace limit");

  a_clear_after_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |=> (idx_q == '0 && tail_q == '0))
    else $error("trace state not cleared after trace end");

endmodule

// File: sv/twph_div.sv
// Iterative restoring divider: rounded signed fixed point quotient, one bit per cycle.
`timescale 1ns / 1ps

module twph_div
  import twph_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic signed [SUM_W-1:0] num_i,
  input  logic [DEN_W-1:0]        den_i,
  output logic                    busy_o,
  output logic                    done_o,
  output logic signed [VAL_W-1:0] quot_o
);

  localparam int DivW = SUM_W + FRAC_BITS + 1;
  localparam int CntW = $clog2(DivW + 1);

  logic [DivW-1:0]  shift_q, shift_d;
  logic [DEN_W-1:0] rem_q, rem_d;
  logic [DEN_W-1:0] den_q;
  logic [CntW-1:0]  cnt_q;
  logic             busy_q, done_q, neg_q;
  logic [SUM_W-1:0] mag;
  logic [DivW-1:0]  dividend;
  logic [DEN_W:0]   trial;
  logic             ge;
  logic [VAL_W-1:0] q_low;

  assign mag      = num_i[SUM_W-1] ? SUM_W'(-num_i) : SUM_W'(num_i);
  // Half the divisor added up front rounds the magnitude to nearest, ties away.
  assign dividend = (DivW'(mag) << FRAC_BITS) + DivW'(den_i >> 1);

  assign trial   = {rem_q, shift_q[DivW-1]};
  assign ge      = (trial >= {1'b0, den_q});
  assign rem_d   = ge ? DEN_W'(trial - {1'b0, den_q}) : DEN_W'(trial);
  assign shift_d = {shift_q[DivW-2:0], ge};

  assign q_low  = shift_q[VAL_W-1:0];
  assign quot_o = neg_q ? -q_low : q_low;
  assign busy_o = busy_q;
  assign done_o = done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(DivW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      shift_q <= dividend;
      rem_q   <= '0;
      den_q   <= den_i;
      neg_q   <= num_i[SUM_W-1];
    end else if (busy_q) begin
      shift_q <= shift_d;
      rem_q   <= rem_d;
    end
  end

  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(busy_q))
    else $error("divider done without a running division");

endmodule

// File: sv/twph_back.sv
// Back end: takes classified traces, runs the divisions and holds the result word.
`timescale 1ns / 1ps

module twph_back
  import twph_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  job_t        head_i,
  input  queue_stat_t q_stat_i,
  output logic        pop_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output out_t        out_data_o
);

  back_state_e             state_q, state_d;
  job_t                    job_q;
  logic                    job_load;
  logic signed [VAL_W-1:0] acc_q, acc_d;
  out_t                    out_q, out_d;
  logic                    out_valid_q, out_load, slot_free;
  logic                    div_start, div_busy, div_done;
  logic signed [SUM_W-1:0] div_num;
  logic [DEN_W-1:0]        div_den;
  logic signed [VAL_W-1:0] div_quot;

  twph_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (div_num),
    .den_i  (div_den),
    .busy_o (div_busy),
    .done_o (div_done),
    .quot_o (div_quot)
  );

  assign slot_free   = ~out_valid_q | out_ready_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    state_d      = state_q;
    pop_o        = 1'b0;
    job_load     = 1'b0;
    acc_d        = acc_q;
    out_load     = 1'b0;
    out_d.value  = '0;
    out_d.status = ST_OK;
    div_start    = 1'b0;
    div_num      = head_i.num_a;
    div_den      = head_i.den_a;
    unique case (state_q)
      BK_IDLE: begin
        if (q_stat_i.valid) begin
          if (head_i.kind == JOB_STATUS) begin
            if (slot_free) begin
              pop_o        = 1'b1;
              out_load     = 1'b1;
              out_d.status = head_i.status;
            end
          end else begin
            pop_o     = 1'b1;
            job_load  = 1'b1;
            div_start = 1'b1;
            state_d   = BK_DIV_A;
          end
        end
      end
      BK_DIV_A: begin
        div_num = job_q.num_b;
        div_den = job_q.den_b;
        if (div_done) begin
          acc_d = div_quot;
          if (job_q.kind == JOB_WINDOW) begin
            div_start = 1'b1;
            state_d   = BK_DIV_B;
          end else begin
            state_d = BK_DONE;
          end
        end
      end
      BK_DIV_B: begin
        if (div_done) begin
          // Window mean minus baseline mean.
          acc_d   = acc_q - div_quot;
          state_d = BK_DONE;
        end
      end
      BK_DONE: begin
        if (slot_free) begin
          out_load     = 1'b1;
          out_d.value  = acc_q;
          out_d.status = ST_OK;
          state_d      = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_load | (out_valid_q & ~out_ready_i);
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    if (job_load) begin
      job_q <= head_i;
    end
    if (out_load) begin
      out_q <= out_d;
    end
  end

  a_second_div_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == BK_DIV_B |-> job_q.kind == JOB_WINDOW)
    else $error("second division for a job that needs one");

  a_start_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !div_busy)
    else $error("division started while divider busy");

endmodule

// File: sv/trace_window_pulse_height.sv
// Top level of the trace window pulse height block: register file, front, queue, back.
//
//   channel  signals                                   direction  moves
//   in       in_valid_i / in_ready_o / in_data_i       input      one trace sample a word
//   out      out_valid_o / out_ready_i / out_data_o    output     one result word a trace
//   cfg      cfg_valid_i / cfg_ready_o / cfg_index_i,  input      one register write a word
//            cfg_data_i
//
// Samples are taken one a cycle; only the final word of a trace waits, and only while the
// job queue is full. A window trace runs two divisions in the back end and a height trace
// one, on the shared one-bit-per-cycle divider.
// Reset is asynchronous and active low; it clears the registers to zero and the trace state.
// A stalled output keeps its word while the front end keeps accumulating the next traces.
`timescale 1ns / 1ps

module trace_window_pulse_height
  import twph_pkg::*;
#(
  parameter int EdgeSamples = EDGE_SAMPLES,
  parameter int QueueDepth  = QUEUE_DEPTH
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  in_t                   in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output out_t                  out_data_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  cfg_t        cfg_q;
  job_t        push_job, head_job;
  logic        push, pop;
  queue_stat_t q_stat;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_MODE:       cfg_q.mode           <= cfg_data_i[0];
        REG_BASE_START: cfg_q.baseline_start <= IDX_W'(cfg_data_i);
        REG_BASE_END:   cfg_q.baseline_end   <= IDX_W'(cfg_data_i);
        REG_WIN_START:  cfg_q.window_start   <= IDX_W'(cfg_data_i);
        REG_WIN_END:    cfg_q.window_end     <= IDX_W'(cfg_data_i);
        default: ;
      endcase
    end
  end

  twph_front #(
    .EdgeSamples(EdgeSamples)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .in_data_i (in_data_i),
    .q_stat_i  (q_stat),
    .push_o    (push),
    .job_o     (push_job)
  );

  twph_queue #(
    .Depth(QueueDepth)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_data_i(push_job),
    .pop_i      (pop),
    .head_o     (head_job),
    .stat_o     (q_stat)
  );

  twph_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .head_i     (head_job),
    .q_stat_i   (q_stat),
    .pop_o      (pop),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

endmodule

// File: sim/twph_result_checker.sv
// Predicts and checks the result words of the trace window pulse height block.
`timescale 1ns / 1ps

module twph_result_checker
  import twph_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  in_ready_i,
  input  in_t                   in_data_i,
  input  logic                  out_valid_i,
  input  logic                  out_ready_i,
  input  out_t                  out_data_i,
  input  logic                  cfg_valid_i,
  input  logic                  cfg_ready_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output int                    fail_count_o,
  output int                    pending_o,
  output int                    results_o,
  output logic [3:0]            status_seen_o
);

  localparam int MAX_REPORTS = 10;

  cfg_t   regs = '0;
  int     trace_len;
  longint base_acc;
  longint win_acc;
  longint head_acc;
  longint tail_acc;
  longint tail_hist [EDGE_SAMPLES];
  out_t   expected_heights [$];
  int     fails;
  int     results;
  logic [3:0] seen = '0;

  initial begin
    fail_count_o  = 0;
    pending_o     = 0;
    results_o     = 0;
    status_seen_o = '0;
  end

  // num * 2^FRAC_BITS / den, nearest, ties away from zero
  function automatic longint round_quot(longint num, longint den);
    longint mag;
    longint q;
    mag = (num < 0) ? -num : num;
    q   = ((mag <<< FRAC_BITS) + den / 2) / den;
    return (num < 0) ? -q : q;
  endfunction

  task automatic clear_trace();
    trace_len = 0;
    base_acc  = 0;
    win_acc   = 0;
    head_acc  = 0;
    tail_acc  = 0;
    foreach (tail_hist[k]) tail_hist[k] = 0;
  endtask

  task automatic absorb_word(input in_t w);
    longint s;
    longint im;
    longint bm;
    longint diff;
    int     slot;
    out_t   r;
    r.value  = '0;
    r.status = ST_OK;
    if (w.empty_trace) begin
      clear_trace();
      r.status = ST_EMPTY;
      expected_heights.push_back(r);
      return;
    end
    s = $signed(w.sample);
    // count saturates; samples past the maximum length are dropped
    if (trace_len < MAX_TRACE_LEN) begin
      if (trace_len >= int'(regs.baseline_start) && trace_len < int'(regs.baseline_end)) begin
        base_acc += s;
      end
      if (trace_len >= int'(regs.window_start) && trace_len < int'(regs.window_end)) begin
        win_acc += s;
      end
      if (trace_len < EDGE_SAMPLES) begin
        head_acc += s;
      end
      slot = trace_len % EDGE_SAMPLES;
      tail_acc += s - tail_hist[slot];
      tail_hist[slot] = s;
      trace_len++;
    end
    if (!w.last) return;
    if (regs.mode) begin
      if (trace_len < 2 * EDGE_SAMPLES) begin
        r.status = ST_SHORT;
      end else begin
        diff    = round_quot(tail_acc - head_acc, EDGE_SAMPLES);
        r.value = diff[VAL_W-1:0];
      end
    end else if (trace_len < int'(regs.window_end) || trace_len < int'(regs.baseline_end)) begin
      r.status = ST_SHORT;
    end else if (regs.window_end <= regs.window_start ||
                 regs.baseline_end <= regs.baseline_start) begin
      r.status = ST_NO_WINDOW;
    end else begin
      im      = round_quot(win_acc, int'(regs.window_end) - int'(regs.window_start));
      bm      = round_quot(base_acc, int'(regs.baseline_end) - int'(regs.baseline_start));
      diff    = im - bm;
      r.value = diff[VAL_W-1:0];
    end
    expected_heights.push_back(r);
    clear_trace();
  endtask

  task automatic report(input string what, input longint want, input longint got);
    fails++;
    if (fails <= MAX_REPORTS) begin
      $display("%0t: %s mismatch: expected %0d, got %0d", $time, what, want, got);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    out_t want;
    if (!rst_ni) begin
      regs = '0;
      clear_trace();
      expected_heights.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          REG_MODE:       regs.mode           = cfg_data_i[0];
          REG_BASE_START: regs.baseline_start = cfg_data_i;
          REG_BASE_END:   regs.baseline_end   = cfg_data_i;
          REG_WIN_START:  regs.window_start   = cfg_data_i;
          REG_WIN_END:    regs.window_end     = cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) begin
        absorb_word(in_data_i);
      end
      if (out_valid_i && out_ready_i) begin
        results++;
        seen[out_data_i.status] = 1'b1;
        if (expected_heights.size() == 0) begin
          fails++;
          if (fails <= MAX_REPORTS) begin
            $display("%0t: result word with nothing expected: value %0d status %0d",
                     $time, $signed(out_data_i.value), out_data_i.status);
          end
        end else begin
          want = expected_heights.pop_front();
          if (out_data_i.value !== want.value) begin
            report("value", $signed(want.value), $signed(out_data_i.value));
          end
          if (out_data_i.status !== want.status) begin
            report("status", want.status, out_data_i.status);
          end
        end
      end
    end
    fail_count_o  <= fails;
    pending_o     <= expected_heights.size();
    results_o     <= results;
    status_seen_o <= seen;
  end

endmodule

// File: sim/trace_window_pulse_height_tb.sv
// Stimulus and verdict for the trace window pulse height block.
`timescale 1ns / 1ps

module trace_window_pulse_height_tb;
  import twph_pkg::*;

  localparam int RANDOM_ITEMS   = 1250;
  localparam int DRAIN_CYCLES   = 120;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int HOLD_OFF       = 400;
  localparam int PRESSURE_PHASE = 12;
  localparam int IDX_TOP        = (1 << CFG_IDX_W) - 1;
  localparam int DATA_TOP       = (1 << CFG_DATA_W) - 1;
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7FFF;
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;

  typedef enum int {
    SHAPE_RANDOM,
    SHAPE_RAIL,
    SHAPE_SMALL,
    SHAPE_HIGH,
    SHAPE_LOW,
    SHAPE_MIXED
  } shape_e;

  logic                  clk;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  in_t                   in_data   = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_t                  out_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  int         fail_count;
  int         pending;
  int         results;
  logic [3:0] status_seen;

  int in_gap_max      = 0;
  int out_stall_max   = 0;
  int hold_off_cycles = 0;
  int items_sent      = 0;
  int traces_sent     = 0;
  int settings_used   = 0;
  int quiet_cycles    = 0;

  trace_window_pulse_height dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  twph_result_checker checker_i (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_ready_i    (in_ready),
    .in_data_i     (in_data),
    .out_valid_i   (out_valid),
    .out_ready_i   (out_ready),
    .out_data_i    (out_data),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_i   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data),
    .fail_count_o  (fail_count),
    .pending_o     (pending),
    .results_o     (results),
    .status_seen_o (status_seen)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // end the run if no word moves on any channel for too long
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("%0t: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("simulation failed");
      $finish;
    end
  end

  // result side: random stalls, plus one long hold when requested
  initial begin
    int stall;
    int hold;
    forever begin
      if (hold_off_cycles > 0) begin
        hold            = hold_off_cycles;
        hold_off_cycles = 0;
        out_ready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      stall = $urandom_range(0, out_stall_max);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  function automatic logic signed [SAMPLE_W-1:0] pick_sample(shape_e shape);
    if (shape == SHAPE_MIXED) shape = shape_e'($urandom_range(0, int'(SHAPE_SMALL)));
    case (shape)
      SHAPE_RAIL:  return ($urandom_range(0, 1) != 0) ? SAMPLE_MAX : SAMPLE_MIN;
      SHAPE_SMALL: return SAMPLE_W'($urandom_range(0, 200)) - 16'sd100;
      SHAPE_HIGH:  return SAMPLE_MAX;
      SHAPE_LOW:   return SAMPLE_MIN;
      default:     return SAMPLE_W'($urandom);
    endcase
  endfunction

  task automatic send_word(input in_t w);
    int gap;
    gap = $urandom_range(0, in_gap_max);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic send_trace(input int len, input shape_e shape);
    in_t w;
    for (int k = 0; k < len; k++) begin
      w.sample      = pick_sample(shape);
      w.last        = (k == len - 1);
      w.empty_trace = 1'b0;
      send_word(w);
    end
    traces_sent++;
  endtask

  // a few samples, then an empty-trace word that throws them away
  task automatic send_empty(input int prefix, input logic last_flag);
    in_t w;
    for (int k = 0; k < prefix; k++) begin
      w.sample      = pick_sample(SHAPE_RANDOM);
      w.last        = 1'b0;
      w.empty_trace = 1'b0;
      send_word(w);
    end
    w.sample      = pick_sample(SHAPE_RANDOM);
    w.last        = last_flag;
    w.empty_trace = 1'b1;
    send_word(w);
    traces_sent++;
  endtask

  // wait until every expected result is out and the back end has gone quiet
  task automatic drain_block();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic apply_settings(input logic m, input int bs, input int be, input int ws,
                                input int we);
    logic [CFG_DATA_W-1:0] mode_word;
    drain_block();
    mode_word    = ($urandom_range(0, 1) != 0) ? CFG_DATA_W'($urandom) : '0;
    mode_word[0] = m;
    write_reg(REG_MODE, mode_word);
    write_reg(REG_BASE_START, CFG_DATA_W'(bs));
    write_reg(REG_BASE_END, CFG_DATA_W'(be));
    write_reg(REG_WIN_START, CFG_DATA_W'(ws));
    write_reg(REG_WIN_END, CFG_DATA_W'(we));
    // unmapped indexes must leave the registers alone
    if ($urandom_range(0, 3) == 0) begin
      write_reg(CFG_IDX_W'($urandom_range(int'(REG_WIN_END) + 1, IDX_TOP)), CFG_DATA_W'($urandom));
    end
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  task automatic pick_pacing();
    int sel;
    sel = $urandom_range(0, 3);
    in_gap_max    = (sel == 0) ? 0 : (sel == 1) ? 3 : 10;
    sel = $urandom_range(0, 3);
    out_stall_max = (sel == 0) ? 0 : (sel == 1) ? 3 : 10;
  endtask

  task automatic random_phase();
    logic m;
    int   kind;
    int   lim;
    int   bs;
    int   be;
    int   ws;
    int   we;
    int   pick;
    int   ntr;
    m    = $urandom_range(0, 1);
    kind = $urandom_range(0, 9);
    lim  = m ? $urandom_range(2 * EDGE_SAMPLES, 48) : $urandom_range(1, 48);
    if (kind < 7) begin
      // proper windows that fit the usual trace length
      bs = $urandom_range(0, lim - 1);
      be = $urandom_range(bs + 1, lim);
      ws = $urandom_range(0, lim - 1);
      we = $urandom_range(ws + 1, lim);
    end else if (kind < 9) begin
      bs = $urandom_range(0, lim);
      be = $urandom_range(0, lim);
      ws = $urandom_range(0, lim);
      we = $urandom_range(0, lim);
    end else begin
      bs = $urandom_range(0, DATA_TOP);
      be = $urandom_range(0, DATA_TOP);
      ws = $urandom_range(0, DATA_TOP);
      we = $urandom_range(0, DATA_TOP);
    end
    apply_settings(m, bs, be, ws, we);
    pick_pacing();
    ntr = $urandom_range(3, 8);
    repeat (ntr) begin
      pick = $urandom_range(0, 9);
      if (pick < 6) begin
        send_trace($urandom_range(lim, lim + 6), shape_e'($urandom_range(0, int'(SHAPE_MIXED))));
      end else if (pick < 8) begin
        send_trace($urandom_range(1, lim), shape_e'($urandom_range(0, int'(SHAPE_MIXED))));
      end else if (pick == 8) begin
        send_empty($urandom_range(0, 5), $urandom_range(0, 1));
      end else begin
        send_trace($urandom_range(1, 3), SHAPE_RANDOM);
      end
    end
  endtask

  // short traces against a stalled output: fill the job queue and stall the input
  task automatic pressure_phase();
    apply_settings(1'b0, 0, 1, 0, 2);
    in_gap_max      = 0;
    out_stall_max   = 2;
    hold_off_cycles = HOLD_OFF;
    repeat (16) begin
      send_trace($urandom_range(1, 3), SHAPE_MIXED);
    end
  endtask

  initial begin
    int phase;
    phase = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // registers at reset: empty window, empty traces, discarded partial trace
    in_gap_max    = 2;
    out_stall_max = 2;
    send_empty(0, 1'b0);
    send_trace(1, SHAPE_HIGH);
    send_empty(2, 1'b1);
    // small proper windows: full trace, then one too short
    apply_settings(1'b0, 0, 2, 2, 5);
    send_trace(5, SHAPE_RAIL);
    send_trace(2, SHAPE_LOW);
    // height mode below the minimum length
    apply_settings(1'b1, 0, 0, 0, 0);
    send_trace(3, SHAPE_SMALL);

    while (items_sent < RANDOM_ITEMS) begin
      if (phase == PRESSURE_PHASE) begin
        pressure_phase();
      end else begin
        random_phase();
      end
      phase++;
    end

    // full-length windows, one maximum trace and one overlong trace
    apply_settings(1'b0, 0, MAX_TRACE_LEN, MAX_TRACE_LEN / 2, MAX_TRACE_LEN);
    in_gap_max    = 0;
    out_stall_max = 3;
    send_trace(MAX_TRACE_LEN, SHAPE_HIGH);
    send_trace(MAX_TRACE_LEN + 4, SHAPE_LOW);
    drain_block();

    $display("run: %0d sample words in %0d traces over %0d register settings,",
             items_sent, traces_sent, settings_used);
    $display("  incl. a %0d-cycle output hold and overlong traces; %0d results, status mask %b",
             HOLD_OFF, results, status_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
